[hdl/rclb_pkg.sv]
// ----------------------------------------------------------------------------
// rclb_pkg: shared types and constants of the register line cache
// Request kinds, result actions, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rclb_pkg;

	localparam int SLOT_W = 16;
	localparam int USE_W  = 32;
	localparam int CFG_W  = 5;
	localparam int LINE_W = 4;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;
	localparam logic [USE_W-1:0] DEAD_USE = '1;

	typedef enum logic [2:0] {
		KIND_READ    = 3'd0,
		KIND_DEFINE  = 3'd1,
		KIND_SCRATCH = 3'd2,
		KIND_END     = 3'd3,
		KIND_FLUSH   = 3'd4,
		KIND_SPILL   = 3'd5,
		KIND_QUERY   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ACT_ANSWER = 2'd0,
		ACT_SPILL  = 2'd1,
		ACT_FILL   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_GENERAL_USED = 2'd0,
		REG_FLOAT_USED   = 2'd1,
		REG_FURTHEST     = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		EM_SPILL_SCAN,
		EM_SPILL_FOUND,
		EM_SPILL_VICTIM,
		EM_FILL,
		EM_ANSWER
	} emit_t;

	typedef struct packed {
		logic  latch;
		logic  init;
		logic  init_pool;
		logic  rd;
		logic  ev;
		logic  adv;
		logic  spill_clear;
		logic  drop;
		logic  hit;
		logic  take;
		logic  end_instr;
		logic  flush_clear;
		logic  set_res;
		logic  set_exh;
		logic  emit;
		emit_t sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       pool;
		logic       idx_done;
		logic       found;
		logic       free_found;
		logic       vic_found;
		logic       ev_spill;
		logic       found_spill;
		logic       vic_spill;
		logic       out_free;
	} sts_t;

endpackage

[hdl/rclb_ctrl.sv]
// ----------------------------------------------------------------------------
// rclb_ctrl: request sequencer of the register line cache
// Steps each request through its line scans, spills, fills and the answer.
// ----------------------------------------------------------------------------
module rclb_ctrl import rclb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_RD, ST_EV, ST_DONE, ST_OSPILL,
		ST_VSPILL, ST_TAKE, ST_FILL, ST_ANS
	} state_t;

	typedef enum logic [2:0] {
		PH_OTHER, PH_OWN, PH_FLUSH0, PH_FLUSH1, PH_Q0, PH_Q1
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		cmd.sel = EM_ANSWER;
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DISP;
				end
			end
			ST_DISP: begin
				priority if (sts.kind == KIND_READ || sts.kind == KIND_DEFINE) begin
					cmd.init = 1'b1; cmd.init_pool = ~sts.pool;
					phase_d = PH_OTHER; state_d = ST_RD;
				end else if (sts.kind == KIND_SCRATCH) begin
					cmd.init = 1'b1; cmd.init_pool = sts.pool;
					phase_d = PH_OWN; state_d = ST_RD;
				end else if (sts.kind == KIND_END) begin
					cmd.end_instr = 1'b1; state_d = ST_ANS;
				end else if (sts.kind == KIND_FLUSH || sts.kind == KIND_SPILL) begin
					cmd.init = 1'b1; cmd.init_pool = 1'b0;
					phase_d = PH_FLUSH0; state_d = ST_RD;
				end else if (sts.kind == KIND_QUERY) begin
					cmd.init = 1'b1; cmd.init_pool = 1'b0;
					phase_d = PH_Q0; state_d = ST_RD;
				end else begin
					state_d = ST_ANS;
				end
			end
			ST_RD: begin
				if (sts.idx_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.rd = 1'b1; state_d = ST_EV;
				end
			end
			ST_EV: begin
				if (phase_q == PH_FLUSH0 || phase_q == PH_FLUSH1) begin
					if (!sts.ev_spill) begin
						cmd.adv = 1'b1; state_d = ST_RD;
					end else if (sts.out_free) begin
						cmd.emit = 1'b1; cmd.sel = EM_SPILL_SCAN;
						cmd.spill_clear = 1'b1; cmd.adv = 1'b1; state_d = ST_RD;
					end
				end else begin
					cmd.ev = 1'b1; cmd.adv = 1'b1; state_d = ST_RD;
				end
			end
			ST_DONE: begin
				unique case (phase_q)
					PH_OTHER: begin
						if (sts.found && sts.kind == KIND_READ && sts.found_spill) begin
							state_d = ST_OSPILL;
						end else begin
							cmd.drop = sts.found;
							cmd.init = 1'b1; cmd.init_pool = sts.pool;
							phase_d = PH_OWN; state_d = ST_RD;
						end
					end
					PH_OWN: begin
						priority if (sts.kind != KIND_SCRATCH && sts.found) begin
							cmd.hit = 1'b1; state_d = ST_ANS;
						end else if (sts.free_found) begin
							state_d = ST_TAKE;
						end else if (sts.vic_found) begin
							state_d = sts.vic_spill ? ST_VSPILL : ST_TAKE;
						end else begin
							cmd.set_exh = 1'b1; state_d = ST_ANS;
						end
					end
					PH_FLUSH0: begin
						cmd.init = 1'b1; cmd.init_pool = 1'b1;
						phase_d = PH_FLUSH1; state_d = ST_RD;
					end
					PH_FLUSH1: begin
						cmd.flush_clear = (sts.kind == KIND_FLUSH);
						state_d = ST_ANS;
					end
					PH_Q0: begin
						cmd.set_res = 1'b1;
						cmd.init = 1'b1; cmd.init_pool = 1'b1;
						phase_d = PH_Q1; state_d = ST_RD;
					end
					default: begin
						cmd.set_res = 1'b1; state_d = ST_ANS;
					end
				endcase
			end
			ST_OSPILL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.sel = EM_SPILL_FOUND; cmd.drop = 1'b1;
					cmd.init = 1'b1; cmd.init_pool = sts.pool;
					phase_d = PH_OWN; state_d = ST_RD;
				end
			end
			ST_VSPILL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.sel = EM_SPILL_VICTIM; state_d = ST_TAKE;
				end
			end
			ST_TAKE: begin
				cmd.take = 1'b1;
				state_d  = (sts.kind == KIND_READ) ? ST_FILL : ST_ANS;
			end
			ST_FILL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.sel = EM_FILL; state_d = ST_ANS;
				end
			end
			ST_ANS: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.sel = EM_ANSWER; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_OTHER;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

[hdl/rclb_dpath.sv]
// ----------------------------------------------------------------------------
// rclb_dpath: line state, line memory and scan logic of the register cache
// Holds the line flags, the slot and use-time memory, the scan results, the
// use clock, the configuration and the result register.
// ----------------------------------------------------------------------------
module rclb_dpath import rclb_pkg::*; #(
	parameter int LINES_PER_POOL = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic [2:0]        in_kind,
	input  logic [SLOT_W-1:0] in_slot,
	input  logic              in_pool,
	input  logic [USE_W-1:0]  in_next_use,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_action,
	output logic [SLOT_W-1:0] out_slot,
	output logic              out_pool,
	output logic [LINE_W-1:0] out_line,
	output logic              out_resident,
	output logic              out_exhausted
);

	localparam int L     = LINES_PER_POOL;
	localparam int NE    = 2 * L;
	localparam int LW    = (L > 1) ? $clog2(L) : 1;
	localparam int IW    = $clog2(L + 1);
	localparam int EW    = $clog2(NE);
	localparam int MEM_W = SLOT_W + 2 * USE_W;

	// Configuration, request and flags.
	logic [CFG_W-1:0]  gcnt_q, fcnt_q;
	logic              mode_q;
	logic [2:0]        kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic              pool_q;
	logic [USE_W-1:0]  nu_q;
	logic [NE-1:0]     occ_q, dirty_q, scr_q, pin_q;
	logic [USE_W-1:0]  clock_q;

	// Line memory: slot, last use, next use.
	logic [MEM_W-1:0]  mem [NE];
	logic [MEM_W-1:0]  rd_q;

	// Scan state.
	logic              scan_pool_q;
	logic [IW-1:0]     idx_q;
	logic              found_q, free_found_q, vic_found_q;
	logic [LW-1:0]     found_idx_q, free_idx_q, vic_idx_q;
	logic [USE_W-1:0]  vic_key_q;
	logic [SLOT_W-1:0] vic_slot_q;
	logic [LW-1:0]     ans_line_q;
	logic              res_q, exh_q;

	function automatic logic [EW-1:0] ent(input logic p, input logic [LW-1:0] i);
		ent = EW'(p ? L : 0) + EW'(i);
	endfunction

	function automatic logic [IW-1:0] sat(input logic [CFG_W-1:0] c);
		sat = (32'(c) > L) ? IW'(L) : IW'(c);
	endfunction

	logic [IW-1:0]     cnt_g, cnt_f, scan_cnt;
	logic [EW-1:0]     se, fe, ve, we;
	logic [LW-1:0]     take_idx, wr_idx;
	logic [SLOT_W-1:0] rd_slot;
	logic [USE_W-1:0]  rd_lu, rd_nu, key;
	logic              match, better;

	assign cnt_g    = sat(gcnt_q);
	assign cnt_f    = sat(fcnt_q);
	assign scan_cnt = scan_pool_q ? cnt_f : cnt_g;
	assign se       = ent(scan_pool_q, idx_q[LW-1:0]);
	assign fe       = ent(scan_pool_q, found_idx_q);
	assign ve       = ent(scan_pool_q, vic_idx_q);
	assign take_idx = free_found_q ? free_idx_q : vic_idx_q;
	assign wr_idx   = cmd.hit ? found_idx_q : take_idx;
	assign we       = ent(pool_q, wr_idx);
	assign rd_slot  = rd_q[MEM_W-1 -: SLOT_W];
	assign rd_lu    = rd_q[2*USE_W-1 -: USE_W];
	assign rd_nu    = rd_q[USE_W-1:0];
	assign match    = occ_q[se] && !scr_q[se] && (rd_slot == slot_q);
	assign key      = mode_q ? rd_nu : rd_lu;
	assign better   = mode_q ? (key > vic_key_q) : (key < vic_key_q);

	// Status towards the controller.
	always_comb begin
		sts.kind        = kind_q;
		sts.pool        = pool_q;
		sts.idx_done    = (idx_q >= scan_cnt);
		sts.found       = found_q;
		sts.free_found  = free_found_q;
		sts.vic_found   = vic_found_q;
		sts.ev_spill    = occ_q[se] && dirty_q[se] && !scr_q[se];
		sts.found_spill = occ_q[fe] && dirty_q[fe] && !scr_q[fe];
		sts.vic_spill   = occ_q[ve] && dirty_q[ve] && !scr_q[ve];
		sts.out_free    = !out_valid || out_ready;
	end

	// Configuration registers and use clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcnt_q  <= CFG_W'(16);
			fcnt_q  <= CFG_W'(16);
			mode_q  <= 1'b0;
			clock_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GENERAL_USED: gcnt_q <= cfg_wdata;
					REG_FLOAT_USED:   fcnt_q <= cfg_wdata;
					REG_FURTHEST:     mode_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.hit || cmd.take) clock_q <= clock_q + 1'b1;
		end
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= in_kind;
			slot_q <= in_slot;
			pool_q <= in_pool;
			nu_q   <= in_next_use;
		end
	end

	// Line flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			dirty_q <= '0;
			scr_q   <= '0;
			pin_q   <= '0;
		end else begin
			if (cmd.drop) begin
				occ_q[fe]   <= 1'b0;
				dirty_q[fe] <= 1'b0;
			end
			if (cmd.spill_clear) dirty_q[se] <= 1'b0;
			if (cmd.hit) begin
				pin_q[we] <= 1'b1;
				if (kind_q == KIND_DEFINE) dirty_q[we] <= 1'b1;
			end
			if (cmd.take) begin
				occ_q[we]   <= 1'b1;
				scr_q[we]   <= (kind_q == KIND_SCRATCH);
				dirty_q[we] <= (kind_q == KIND_DEFINE);
				pin_q[we]   <= 1'b1;
			end
			for (int e = 0; e < NE; e++) begin
				if ((e < L) ? (e < 32'(cnt_g)) : ((e - L) < 32'(cnt_f))) begin
					if (cmd.end_instr && occ_q[e]) begin
						if (scr_q[e]) occ_q[e] <= 1'b0;
						else pin_q[e] <= 1'b0;
					end
					if (cmd.flush_clear) occ_q[e] <= 1'b0;
				end
			end
		end
	end

	// Line memory write and scan read.
	always_ff @(posedge clk) begin
		if (cmd.hit || cmd.take) begin
			mem[we] <= {(kind_q == KIND_SCRATCH) ? SLOT_W'(0) : slot_q,
				clock_q + 1'b1,
				(kind_q == KIND_SCRATCH) ? DEAD_USE : nu_q};
		end
		if (cmd.rd) rd_q <= mem[se];
	end

	// Scan control: first match, first free line and victim.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pool_q  <= 1'b0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
		end else begin
			if (cmd.init) begin
				scan_pool_q  <= cmd.init_pool;
				idx_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				vic_found_q  <= 1'b0;
			end else begin
				if (cmd.ev) begin
					if (match && !found_q) found_q <= 1'b1;
					if (!occ_q[se] && !free_found_q) free_found_q <= 1'b1;
					if (!pin_q[se]) vic_found_q <= 1'b1;
				end
				if (cmd.adv) idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Scan payload.
	always_ff @(posedge clk) begin
		if (cmd.ev) begin
			if (match && !found_q) found_idx_q <= idx_q[LW-1:0];
			if (!occ_q[se] && !free_found_q) free_idx_q <= idx_q[LW-1:0];
			if (!pin_q[se] && (!vic_found_q || better)) begin
				vic_idx_q  <= idx_q[LW-1:0];
				vic_key_q  <= key;
				vic_slot_q <= rd_slot;
			end
		end
	end

	// Answer bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ans_line_q <= '0;
			res_q      <= 1'b0;
			exh_q      <= 1'b0;
		end else begin
			if (cmd.hit || cmd.take) ans_line_q <= wr_idx;
			if (cmd.set_res) res_q <= res_q | found_q;
			if (cmd.set_exh) exh_q <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_resident  <= 1'b0;
			out_exhausted <= 1'b0;
			unique case (cmd.sel)
				EM_SPILL_SCAN: begin
					out_action <= ACT_SPILL; out_slot <= rd_slot;
					out_pool <= scan_pool_q; out_line <= LINE_W'(idx_q);
				end
				EM_SPILL_FOUND: begin
					out_action <= ACT_SPILL; out_slot <= slot_q;
					out_pool <= scan_pool_q; out_line <= LINE_W'(found_idx_q);
				end
				EM_SPILL_VICTIM: begin
					out_action <= ACT_SPILL; out_slot <= vic_slot_q;
					out_pool <= pool_q; out_line <= LINE_W'(vic_idx_q);
				end
				EM_FILL: begin
					out_action <= ACT_FILL; out_slot <= slot_q;
					out_pool <= pool_q; out_line <= LINE_W'(ans_line_q);
				end
				default: begin
					out_action <= ACT_ANSWER;
					out_slot <= (kind_q == KIND_READ || kind_q == KIND_DEFINE ||
						kind_q == KIND_QUERY) ? slot_q : SLOT_W'(0);
					out_pool <= (kind_q == KIND_READ || kind_q == KIND_DEFINE ||
						kind_q == KIND_SCRATCH) ? pool_q : 1'b0;
					out_line      <= LINE_W'(ans_line_q);
					out_resident  <= res_q;
					out_exhausted <= exh_q;
				end
			endcase
		end
	end

endmodule

[hdl/register_cache_lru_belady_core.sv]
// ----------------------------------------------------------------------------
// register_cache_lru_belady_core: two-pool register line cache
// Maps variable slots onto general and float lines with write-back spills,
// fills and LRU or furthest-next-use eviction.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_*       in         request: tuser kind, tdata slot, pool, next use
// m_*       out        result: tuser action, tdata slot, pool, line, flags
// cfg_*     in         register write: index and value, no wait
//
// Requests are sequenced one at a time. A pool scan does a memory read and
// then a compare for each line in use, and then closes. A read or define hit,
// a flush, a spill dirty or a query scans both pools before it emits its
// answer; flush spills ride within the scan. A miss adds a step to take the
// line, the fill beat of a read and one beat per spilled line; a scratch
// scans only its own pool, and end instruction answers without a scan. A
// stalled result register holds the sequencer. Reset clears the line flags
// and the use clock and returns the configuration to its defaults.
// ----------------------------------------------------------------------------
module register_cache_lru_belady_core import rclb_pkg::*; #(
	parameter int LINES_PER_POOL = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// tdata: slot[15:0], pool[16], next_use[48:17], zero[55:49]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// tuser: kind[2:0]
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tdata: out_slot[15:0], out_pool[16], line_index[20:17], resident[21],
	// pool_exhausted[22], zero[23]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// tuser: action[1:0]
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	cmd_t              cmd;
	sts_t              sts;
	logic [SLOT_W-1:0] o_slot;
	logic              o_pool, o_res, o_exh;
	logic [LINE_W-1:0] o_line;

	rclb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rclb_dpath #(.LINES_PER_POOL(LINES_PER_POOL)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_kind       (s_tuser),
		.in_slot       (s_tdata[15:0]),
		.in_pool       (s_tdata[16]),
		.in_next_use   (s_tdata[48:17]),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_action    (m_tuser),
		.out_slot      (o_slot),
		.out_pool      (o_pool),
		.out_line      (o_line),
		.out_resident  (o_res),
		.out_exhausted (o_exh)
	);

	// Only the answer closes a request.
	assign m_tlast = (m_tuser == ACT_ANSWER);
	assign m_tdata = {1'b0, o_exh, o_res, o_line, o_pool, o_slot};

endmodule
